### src/pc2ls_pkg.sv
// Shared types, constants and the table of the point cloud to laser scan block.
package pc2ls_pkg;

  // Default number of scan bins.
  localparam int MAX_BINS_DEF = 1024;

  // CORDIC iteration count and widths of the fixed fields.
  localparam int CORDIC_STEPS = 24;
  localparam int COORD_W      = 19;
  localparam int RANGE_W      = 20;
  localparam int STRENGTH_W   = 16;
  localparam int ANGLE_W      = 16;
  localparam int READ_BIN_W   = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;
  localparam int R2_W         = 38;
  localparam int ROOT_W       = 19;

  // Reset values of the configuration registers.
  localparam logic signed [15:0] ANGLE_LOWEST_RST   = -16'sd32768;
  localparam logic signed [15:0] ANGLE_HIGHEST_RST  = 16'sd32767;
  localparam logic [15:0]        ANGLE_STEP_RST     = 16'd64;
  localparam logic [19:0]        RANGE_LOWEST_RST   = 20'd0;
  localparam logic [19:0]        RANGE_HIGHEST_RST  = 20'd100000;
  localparam logic signed [18:0] HEIGHT_LOWEST_RST  = -19'sd262144;
  localparam logic signed [18:0] HEIGHT_HIGHEST_RST = 19'sd262143;
  localparam logic [19:0]        EMPTY_RANGE_RST    = 20'hFFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_LOWEST   = 3'd0,
    CFG_ANGLE_HIGHEST  = 3'd1,
    CFG_ANGLE_STEP     = 3'd2,
    CFG_RANGE_LOWEST   = 3'd3,
    CFG_RANGE_HIGHEST  = 3'd4,
    CFG_HEIGHT_LOWEST  = 3'd5,
    CFG_HEIGHT_HIGHEST = 3'd6,
    CFG_EMPTY_RANGE    = 3'd7
  } cfg_idx_e;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_START,
    ST_RUN,
    ST_CHECK,
    ST_DIV,
    ST_RD,
    ST_UPD,
    ST_READ,
    ST_READ_OUT
  } state_e;

  // One bin entry as stored in the scan memory.
  typedef struct packed {
    logic [RANGE_W-1:0]    range;
    logic [STRENGTH_W-1:0] strength;
  } bin_entry_t;

  // Arctangent table, 2^32 units per turn.
  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### src/pc2ls_cordic.sv
// Iterative CORDIC vectoring unit that turns x and y into a binary angle.
module pc2ls_cordic import pc2ls_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  output logic                      busy_o,
  output logic signed [ANGLE_W-1:0] angle_o
);

  localparam int W = 36;

  logic                busy_q;
  logic [4:0]          cnt_q;
  logic signed [W-1:0] cx_q, cy_q;
  logic [31:0]         acc_q;
  logic signed [W-1:0] xs, ys, dx, dy;
  logic [31:0]         acc_rnd;

  // Scale the coordinates by 4096 and shift by the iteration count.
  assign xs = W'(x_i) <<< 12;
  assign ys = W'(y_i) <<< 12;
  assign dx = cx_q >>> cnt_q;
  assign dy = cy_q >>> cnt_q;

  // Control: busy while the iterations run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: one micro-rotation per cycle, frozen once y reaches zero.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      if (xs < 0) begin
        cx_q  <= -xs;
        cy_q  <= -ys;
        acc_q <= 32'h8000_0000;
      end else begin
        cx_q  <= xs;
        cy_q  <= ys;
        acc_q <= 32'h0;
      end
    end else if (busy_q && cy_q != 0) begin
      if (cy_q > 0) begin
        cx_q  <= cx_q + dy;
        cy_q  <= cy_q - dx;
        acc_q <= acc_q + atan_tab(cnt_q);
      end else begin
        cx_q  <= cx_q - dy;
        cy_q  <= cy_q + dx;
        acc_q <= acc_q - atan_tab(cnt_q);
      end
    end
  end

  // Round to 65536 units per turn.
  assign acc_rnd = acc_q + 32'h0000_8000;
  assign angle_o = acc_rnd[31:16];
  assign busy_o  = busy_q;

endmodule

### src/pc2ls_root.sv
// Bit-serial integer square root with an exactness flag.
module pc2ls_root import pc2ls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [R2_W-1:0]   rad_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o,
  output logic              exact_o
);

  localparam int REM_W = ROOT_W + 2;

  logic              busy_q;
  logic [4:0]        cnt_q;
  logic [R2_W-1:0]   rad_q;
  logic [ROOT_W-1:0] res_q;
  logic [REM_W-1:0]  rem_q;
  logic [REM_W+1:0]  rem_sh, trial;

  // Bring down two radicand bits and try the next result bit.
  assign rem_sh = {rem_q, rad_q[R2_W-1:R2_W-2]};
  assign trial  = (REM_W + 2)'({res_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(ROOT_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // One result bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rad_q <= rad_i;
      res_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q <= REM_W'(rem_sh - trial);
        res_q <= {res_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q <= REM_W'(rem_sh);
        res_q <= {res_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o  = busy_q;
  assign root_o  = res_q;
  assign exact_o = (rem_q == '0);

endmodule

### src/pc2ls_div.sv
// Restoring divider, one quotient bit per cycle, for the bin index.
module pc2ls_div import pc2ls_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ANGLE_W-1:0]   dividend_i,
  input  logic [ANGLE_W-1:0]   divisor_i,
  output logic                 busy_o,
  output logic [ANGLE_W-1:0]   quo_o,
  output logic                 rem_zero_o
);

  logic               busy_q;
  logic [4:0]         cnt_q;
  logic [ANGLE_W-1:0] dvd_q, dvs_q, rem_q;
  logic [ANGLE_W:0]   rem_sh;

  assign rem_sh = {rem_q, dvd_q[ANGLE_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(ANGLE_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // The dividend register collects the quotient bits as it shifts out.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q <= ANGLE_W'(rem_sh - {1'b0, dvs_q});
        dvd_q <= {dvd_q[ANGLE_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[ANGLE_W-1:0];
        dvd_q <= {dvd_q[ANGLE_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o     = busy_q;
  assign quo_o      = dvd_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

### src/point_cloud_to_laser_scan.sv
// Top level: sequencer, configuration registers and scan bin memory.
// A point that passes every window goes from its accept through two squaring states,
// a start state, the CORDIC iterations (root in parallel), a check, the divide and a
// read-modify-write (read, then update) before the next accept is taken.
// Points rejected by range or angle end at the check; by valid flag or height band, at accept.
// A readout reads its bin, then loads the output register once that register is free;
// after reset a clearing pass over every bin blocks items, not configuration.
module point_cloud_to_laser_scan import pc2ls_pkg::*; #(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic                         point_valid_i,
  input  logic signed [COORD_W-1:0]    pos_x_i,
  input  logic signed [COORD_W-1:0]    pos_y_i,
  input  logic signed [COORD_W-1:0]    pos_z_i,
  input  logic [STRENGTH_W-1:0]        echo_strength_i,
  input  logic [READ_BIN_W-1:0]        read_bin_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [RANGE_W-1:0]           bin_range_o,
  output logic [STRENGTH_W-1:0]        bin_strength_o,
  output logic [READ_BIN_W-1:0]        bin_number_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  // Configuration registers.
  logic signed [15:0] alo_q, ahi_q;
  logic [15:0]        step_q;
  logic [19:0]        rlo_q, rhi_q, empty_q;
  logic signed [18:0] hlo_q, hhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alo_q   <= ANGLE_LOWEST_RST;
      ahi_q   <= ANGLE_HIGHEST_RST;
      step_q  <= ANGLE_STEP_RST;
      rlo_q   <= RANGE_LOWEST_RST;
      rhi_q   <= RANGE_HIGHEST_RST;
      hlo_q   <= HEIGHT_LOWEST_RST;
      hhi_q   <= HEIGHT_HIGHEST_RST;
      empty_q <= EMPTY_RANGE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ANGLE_LOWEST:   alo_q   <= cfg_data_i[15:0];
        CFG_ANGLE_HIGHEST:  ahi_q   <= cfg_data_i[15:0];
        CFG_ANGLE_STEP:     step_q  <= cfg_data_i[15:0];
        CFG_RANGE_LOWEST:   rlo_q   <= cfg_data_i;
        CFG_RANGE_HIGHEST:  rhi_q   <= cfg_data_i;
        CFG_HEIGHT_LOWEST:  hlo_q   <= cfg_data_i[18:0];
        CFG_HEIGHT_HIGHEST: hhi_q   <= cfg_data_i[18:0];
        CFG_EMPTY_RANGE:    empty_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state and item registers.
  state_e state_q, state_d;
  logic [BIN_W-1:0]            clr_q;
  logic                        out_valid_q;
  logic signed [COORD_W-1:0]   x_q, y_q;
  logic [STRENGTH_W-1:0]       str_q;
  logic [READ_BIN_W-1:0]       rbin_q;
  logic [R2_W-1:0]             prod_q, r2_q;
  logic [RANGE_W-1:0]          rng_q;
  logic                        tail_q;
  logic [BIN_W-1:0]            bin_q;
  logic [RANGE_W-1:0]          out_range_q;
  logic [STRENGTH_W-1:0]       out_str_q;
  logic [READ_BIN_W-1:0]       out_num_q;

  // Units and memory signals.
  logic                        root_start, cordic_start, div_start;
  logic                        root_busy, cordic_busy, div_busy;
  logic [ROOT_W-1:0]           root_val;
  logic                        root_exact;
  logic signed [ANGLE_W-1:0]   angle;
  logic [ANGLE_W-1:0]          quo;
  logic                        rem_zero;
  logic                        mem_we;
  logic [BIN_W-1:0]            mem_waddr, mem_raddr;
  bin_entry_t                  mem_wdata, mem_rdata_q;
  bin_entry_t                  mem_q [MAX_BINS];

  logic                        accept, height_ok, range_ok, angle_ok, out_load, rbin_in;
  logic [COORD_W-1:0]          sq_abs;
  logic [R2_W-1:0]             sq;
  logic signed [ANGLE_W:0]     span, adiff;
  logic [ANGLE_W-1:0]          step_eff;
  logic [RANGE_W-1:0]          rng_full;
  logic [BIN_W-1:0]            bin_calc, rbin_idx;

  assign accept    = in_valid_i && in_ready_o;
  assign height_ok = (pos_z_i >= hlo_q) && (pos_z_i <= hhi_q);

  // Shared squarer: x in the SQX state, y in the SQY state.
  always_comb begin
    logic signed [COORD_W-1:0] op;
    op     = (state_q == ST_SQX) ? x_q : y_q;
    sq_abs = op[COORD_W-1] ? COORD_W'(-op) : COORD_W'(op);
    sq     = R2_W'(sq_abs) * R2_W'(sq_abs);
  end

  // Range window from the root and its remainder, angle window and bin offset.
  assign rng_full = RANGE_W'(root_val);
  assign range_ok = (rng_full >= rlo_q) && (rng_full <= rhi_q)
                    && !((rng_full == rhi_q) && !root_exact);
  assign angle_ok = (angle >= alo_q) && (angle <= ahi_q);
  assign span     = (ANGLE_W + 1)'(ahi_q) - (ANGLE_W + 1)'(alo_q);
  assign adiff    = (ANGLE_W + 1)'(angle) - (ANGLE_W + 1)'(alo_q);
  assign step_eff = (step_q == '0) ? ANGLE_W'(1) : step_q;

  // Bin clamp: beyond the memory, or landing exactly on the upper angle limit.
  always_comb begin
    if (32'(quo) >= MAX_BINS) begin
      bin_calc = BIN_W'(MAX_BINS - 1);
    end else if (tail_q && rem_zero && quo != '0) begin
      bin_calc = BIN_W'(quo - ANGLE_W'(1));
    end else begin
      bin_calc = BIN_W'(quo);
    end
  end

  assign rbin_idx = BIN_W'(rbin_q);
  assign rbin_in  = (32'(rbin_q) < MAX_BINS);
  assign out_load = (state_q == ST_READ_OUT) && (!out_valid_q || out_ready_i);

  // Next state and unit control.
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    root_start   = 1'b0;
    cordic_start = 1'b0;
    div_start    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = bin_q;
    mem_wdata    = '{range: rng_q, strength: str_q};
    mem_raddr    = bin_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '{range: EMPTY_RANGE_RST, strength: '0};
        if (clr_q == BIN_W'(MAX_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i) begin
            state_d = ST_READ;
          end else if (point_valid_i && height_ok) begin
            state_d = ST_SQX;
          end
        end
      end
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_START;
      ST_START: begin
        root_start   = 1'b1;
        cordic_start = 1'b1;
        state_d      = ST_RUN;
      end
      ST_RUN: begin
        if (!root_busy && !cordic_busy) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (range_ok && angle_ok) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_RD;
        end
      end
      ST_RD:  state_d = ST_UPD;
      ST_UPD: begin
        mem_we  = (rng_q < mem_rdata_q.range);
        state_d = ST_IDLE;
      end
      ST_READ: begin
        mem_raddr = rbin_idx;
        state_d   = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        mem_raddr = rbin_idx;
        mem_waddr = rbin_idx;
        mem_wdata = '{range: empty_q, strength: '0};
        if (out_load) begin
          mem_we  = rbin_in;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + BIN_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      str_q  <= echo_strength_i;
      rbin_q <= read_bin_i;
    end
    if (state_q == ST_SQX) begin
      prod_q <= sq;
    end
    if (state_q == ST_SQY) begin
      r2_q <= prod_q + sq;
    end
    if (state_q == ST_CHECK) begin
      rng_q  <= rng_full;
      tail_q <= (adiff == span);
    end
    if (state_q == ST_DIV && !div_busy) begin
      bin_q <= bin_calc;
    end
    if (out_load) begin
      out_range_q <= rbin_in ? mem_rdata_q.range : empty_q;
      out_str_q   <= rbin_in ? mem_rdata_q.strength : '0;
      out_num_q   <= rbin_q;
    end
  end

  // Scan bin memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  pc2ls_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (r2_q),
    .busy_o  (root_busy),
    .root_o  (root_val),
    .exact_o (root_exact)
  );

  pc2ls_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .x_i     (x_q),
    .y_i     (y_q),
    .busy_o  (cordic_busy),
    .angle_o (angle)
  );

  // The offset is taken straight from the finished angle when the divide starts.
  pc2ls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (adiff[ANGLE_W-1:0]),
    .divisor_i  (step_eff),
    .busy_o     (div_busy),
    .quo_o      (quo),
    .rem_zero_o (rem_zero)
  );

  assign out_valid_o    = out_valid_q;
  assign bin_range_o    = out_range_q;
  assign bin_strength_o = out_str_q;
  assign bin_number_o   = out_num_q;

  // Range and angle are only judged once both iterative units have finished.
  a_units_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> !root_busy && !cordic_busy)
    else $error("check entered while a unit was busy");

  // No item is taken while the clearing pass runs.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o)
    else $error("item accepted during clearing pass");

  // A result appears only from the readout state.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_READ_OUT)
    else $error("result produced outside readout");

  // The bin taken for an update always lies inside the memory.
  a_bin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> 32'(bin_q) < MAX_BINS)
    else $error("bin index beyond memory");

endmodule
